/* rtl/core/lzwc_pkg.sv */
package lzwc_pkg;

    // Width of an emitted code and of one raw byte.
    localparam int CODE_OUT_W = 12;
    localparam int BYTE_W = 8;

    // Codes below this stand for single bytes; learned pairs start here.
    localparam int FIRST_LEARNED = 256;

    // Result of comparing one dictionary entry against the current lookup key.
    typedef struct packed {
        logic owned;  // the entry points back at the probed hash slot
        logic match;  // the entry holds the same (prefix, byte) pair
    } lzwc_cmp_t;

endpackage

/* rtl/core/lzwc_slot_table.sv */
module lzwc_slot_table #(
    parameter int HASH_BITS = 13,
    parameter int CODE_BITS = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [HASH_BITS-1:0] rd_addr,
    output logic [CODE_BITS-1:0] rd_code,
    input  logic                 wr_en,
    input  logic [HASH_BITS-1:0] wr_addr,
    input  logic [CODE_BITS-1:0] wr_code,
    output logic                 clear_done
);
    import lzwc_pkg::*;

    localparam int HASH_DEPTH = 1 << HASH_BITS;

    logic [CODE_BITS-1:0] slot_mem [HASH_DEPTH];
    logic [CODE_BITS-1:0] rd_code_reg;
    logic [HASH_BITS-1:0] clr_cnt_reg;
    logic [HASH_BITS-1:0] clr_cnt_next;
    logic                 clearing_reg;
    logic                 clearing_next;

    // After reset every slot is swept to code zero, which never counts as a
    // learned code, so stale or unknown contents can never look occupied.
    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {HASH_BITS{1'b1}}) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            slot_mem[clr_cnt_reg] <= '0;
        end else if (wr_en) begin
            slot_mem[wr_addr] <= wr_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_code_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_code    = rd_code_reg;
    assign clear_done = !clearing_reg;

endmodule

/* rtl/core/lzwc_pair_store.sv */
module lzwc_pair_store #(
    parameter int HASH_BITS = 13,
    parameter int CODE_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          rd_en,
    input  logic [CODE_BITS-1:0]          rd_addr,
    input  logic [CODE_BITS-1:0]          key_prefix,
    input  logic [lzwc_pkg::BYTE_W-1:0]   key_byte,
    input  logic [HASH_BITS-1:0]          key_slot,
    output lzwc_pkg::lzwc_cmp_t           cmp,
    input  logic                          wr_en,
    input  logic [CODE_BITS-1:0]          wr_addr,
    input  logic [CODE_BITS-1:0]          wr_prefix,
    input  logic [lzwc_pkg::BYTE_W-1:0]   wr_byte,
    input  logic [HASH_BITS-1:0]          wr_slot
);
    import lzwc_pkg::*;

    localparam int ENTRY_W = CODE_BITS + BYTE_W + HASH_BITS;
    localparam int DEPTH = 1 << CODE_BITS;

    // Each learned code keeps its pair and the hash slot that refers to it.
    logic [ENTRY_W-1:0]   entry_mem [DEPTH];
    logic [ENTRY_W-1:0]   rd_entry_reg;
    logic [CODE_BITS-1:0] ent_prefix;
    logic [BYTE_W-1:0]    ent_byte;
    logic [HASH_BITS-1:0] ent_slot;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= {wr_prefix, wr_byte, wr_slot};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_entry_reg <= entry_mem[rd_addr];
        end
    end

    assign {ent_prefix, ent_byte, ent_slot} = rd_entry_reg;

    assign cmp.owned = (ent_slot == key_slot);
    assign cmp.match = (ent_prefix == key_prefix) && (ent_byte == key_byte);

endmodule

/* rtl/core/lzw_byte_compressor.sv */
// LZW byte compressor. Bytes enter on the s_ request channel, one per request, with
// s_stream_end marking the last byte of a stream; codes leave on the m_ channel
// with m_final_code set on the last code of a stream. The dictionary is found
// through a hash table of 2^(clog2(DICT_DEPTH)+1) slots held in block memory:
// each probe reads a slot, then the dictionary entry it names, then compares.
// The first byte of a stream only opens the prefix. A later byte ends its search
// when a probe hits the matching pair, finds an empty slot, or finds a slot that
// names an entry belonging to another slot; a slot that names a different pair
// owned by it sends the search on to the next slot, and the end-of-stream code
// follows the last byte. A code that must be emitted also waits while the previous
// code is still pending on the m_ channel. The table is kept at most half full,
// so collisions are short. After reset the block sweeps every slot of the hash
// table to code zero before it takes its first byte. An emitted code waits in an
// output register, so the next byte is taken while it is still pending.
module lzw_byte_compressor #(
    parameter int DICT_DEPTH = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lzwc_pkg::BYTE_W-1:0]       s_data_byte,
    input  logic                              s_stream_end,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lzwc_pkg::CODE_OUT_W-1:0]   m_code,
    output logic                              m_final_code
);
    import lzwc_pkg::*;

    localparam int CODE_BITS = $clog2(DICT_DEPTH);
    localparam int HASH_BITS = CODE_BITS + 1;
    localparam int NFC_BITS  = $clog2(DICT_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SLOT  = 6'b000010,
        S_CODE  = 6'b000100,
        S_CMP   = 6'b001000,
        S_MISS  = 6'b010000,
        S_FINAL = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [CODE_BITS-1:0] prefix_reg, prefix_next;
    logic                 held_reg, held_next;
    logic [NFC_BITS-1:0]  nfc_reg, nfc_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic                 last_reg, last_next;
    logic [HASH_BITS-1:0] probe_reg, probe_next;
    logic [CODE_BITS-1:0] cand_reg, cand_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CODE_OUT_W-1:0] m_code_reg, m_code_next;
    logic                 m_final_reg, m_final_next;

    logic                 clear_done;
    logic [CODE_BITS-1:0] slot_code;
    lzwc_cmp_t            cmp;
    logic                 accept;
    logic                 out_free;
    logic                 slot_live;
    logic                 dict_room;
    logic                 insert;
    logic [HASH_BITS-1:0] hash_key;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && clear_done;

    // Prefix in the low bits and the byte folded onto the top of the index.
    assign hash_key = HASH_BITS'(prefix_reg)
                    ^ (HASH_BITS'(s_data_byte) << (HASH_BITS - BYTE_W));

    // A slot only counts when it names a code learned in the current stream.
    assign slot_live = (slot_code >= CODE_BITS'(FIRST_LEARNED))
                    && (NFC_BITS'(slot_code) < nfc_reg);
    assign dict_room = nfc_reg < NFC_BITS'(DICT_DEPTH);
    assign insert    = (state_reg == S_MISS) && out_free && dict_room;

    lzwc_slot_table #(
        .HASH_BITS (HASH_BITS),
        .CODE_BITS (CODE_BITS)
    ) u_slot_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (state_reg == S_SLOT),
        .rd_addr    (probe_reg),
        .rd_code    (slot_code),
        .wr_en      (insert),
        .wr_addr    (probe_reg),
        .wr_code    (nfc_reg[CODE_BITS-1:0]),
        .clear_done (clear_done)
    );

    lzwc_pair_store #(
        .HASH_BITS (HASH_BITS),
        .CODE_BITS (CODE_BITS)
    ) u_pair_store (
        .aclk       (aclk),
        .rd_en      (state_reg == S_CODE),
        .rd_addr    (slot_code),
        .key_prefix (prefix_reg),
        .key_byte   (byte_reg),
        .key_slot   (probe_reg),
        .cmp        (cmp),
        .wr_en      (insert),
        .wr_addr    (nfc_reg[CODE_BITS-1:0]),
        .wr_prefix  (prefix_reg),
        .wr_byte    (byte_reg),
        .wr_slot    (probe_reg)
    );

    always_comb begin
        state_next   = state_reg;
        prefix_next  = prefix_reg;
        held_next    = held_reg;
        nfc_next     = nfc_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        probe_next   = probe_reg;
        cand_next    = cand_reg;
        m_valid_next = m_valid_reg;
        m_code_next  = m_code_reg;
        m_final_next = m_final_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    byte_next  = s_data_byte;
                    last_next  = s_stream_end;
                    probe_next = hash_key;
                    if (!held_reg) begin
                        // The first byte of a stream only opens the prefix.
                        prefix_next = CODE_BITS'(s_data_byte);
                        held_next   = 1'b1;
                        state_next  = s_stream_end ? S_FINAL : S_IDLE;
                    end else begin
                        state_next = S_SLOT;
                    end
                end
            end
            S_SLOT: begin
                state_next = S_CODE;
            end
            S_CODE: begin
                cand_next  = slot_code;
                state_next = slot_live ? S_CMP : S_MISS;
            end
            S_CMP: begin
                priority if (!cmp.owned) begin
                    state_next = S_MISS;
                end else if (cmp.match) begin
                    prefix_next = cand_reg;
                    state_next  = last_reg ? S_FINAL : S_IDLE;
                end else begin
                    probe_next = probe_reg + 1'b1;
                    state_next = S_SLOT;
                end
            end
            S_MISS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_code_next  = CODE_OUT_W'(prefix_reg);
                    m_final_next = 1'b0;
                    if (dict_room) begin
                        nfc_next = nfc_reg + 1'b1;
                    end
                    prefix_next = CODE_BITS'(byte_reg);
                    state_next  = last_reg ? S_FINAL : S_IDLE;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_code_next  = CODE_OUT_W'(prefix_reg);
                    m_final_next = 1'b1;
                    nfc_next     = NFC_BITS'(FIRST_LEARNED);
                    held_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            prefix_reg  <= '0;
            held_reg    <= 1'b0;
            nfc_reg     <= NFC_BITS'(FIRST_LEARNED);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            prefix_reg  <= prefix_next;
            held_reg    <= held_next;
            nfc_reg     <= nfc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        last_reg    <= last_next;
        probe_reg   <= probe_next;
        cand_reg    <= cand_next;
        m_code_reg  <= m_code_next;
        m_final_reg <= m_final_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_code       = m_code_reg;
    assign m_final_code = m_final_reg;

endmodule

/* rtl/core/lzwc_checker.sv */
module lzwc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [lzwc_pkg::BYTE_W-1:0]     s_data_byte,
    input logic                            s_stream_end,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [lzwc_pkg::CODE_OUT_W-1:0] m_code,
    input logic                            m_final_code
);
    import lzwc_pkg::*;

    // The hash table sweep keeps the block busy right after reset.
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("byte request taken during the post-reset sweep");

    // A waiting byte request keeps its payload until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=>
            (s_valid && $stable(s_data_byte) && $stable(s_stream_end)))
        else $error("waiting byte request changed or dropped before it was taken");

    // The last byte of a stream always owes a final code, so the block stays busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_stream_end) |=> !s_ready)
        else $error("block ready right after the last byte of a stream");

    // No code can be produced in the cycle right after a byte is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("code appeared one cycle after a byte request");

    // A pending code holds until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_code) && $stable(m_final_code)))
        else $error("pending code changed or dropped before it was taken");

endmodule

bind lzw_byte_compressor lzwc_checker u_lzwc_checker (.*);
